// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL that carries concurrent checks.
// No dependencies; each macro takes its own clock and active-low reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// cond must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// cons must hold in the same cycle as ante
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// cons must hold in the cycle after ante
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/uat_pkg.sv =====
// Shared types and constants for the card allow-list table.
// No dependencies; used by the channel interfaces and the top level.
`timescale 1ns / 1ps

package uat_pkg;

    localparam int MAX_ENTRIES_DEF = 32;

    localparam int OP_W        = 3;
    localparam int ID_W        = 32;
    localparam int INDEX_W     = 8;
    localparam int STATUS_W    = 3;
    localparam int COUNT_OUT_W = 6;

    typedef enum logic [OP_W-1:0] {
        OP_LOOKUP = 3'd0,
        OP_ADD    = 3'd1,
        OP_REMOVE = 3'd2,
        OP_CLEAR  = 3'd3,
        OP_READ   = 3'd4
    } uat_op_t;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK      = 3'd0,
        STS_ABSENT  = 3'd1,
        STS_PRESENT = 3'd2,
        STS_FULL    = 3'd3,
        STS_ZERO    = 3'd4,
        STS_RANGE   = 3'd5
    } uat_status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_READ,
        ST_DONE
    } uat_state_t;

endpackage

// ===== rtl/uat_if.sv =====
// Valid/ready channel interfaces for the card allow-list table:
// command items in, response items out. Depends on uat_pkg.
`timescale 1ns / 1ps

interface uat_cmd_if;
    logic                              valid;
    logic                              ready;
    logic [uat_pkg::OP_W-1:0]          op;
    logic [uat_pkg::ID_W-1:0]          card_id;
    logic [uat_pkg::INDEX_W-1:0]       entry_index;

    modport source (output valid, output op, output card_id, output entry_index,
                    input ready);
    modport sink   (input valid, input op, input card_id, input entry_index,
                    output ready);
endinterface

interface uat_rsp_if;
    logic                              valid;
    logic                              ready;
    logic [uat_pkg::STATUS_W-1:0]      status;
    logic [uat_pkg::ID_W-1:0]          read_id;
    logic [uat_pkg::COUNT_OUT_W-1:0]   entry_count;

    modport source (output valid, output status, output read_id, output entry_count,
                    input ready);
    modport sink   (input valid, input status, input read_id, input entry_count,
                    output ready);
endinterface

// ===== rtl/uid_allowlist_table.sv =====
// Card allow-list table: packed list of 32-bit ids in one synchronous RAM.
// Depends on uat_pkg, uat_if.sv (uat_cmd_if, uat_rsp_if) and assert_macros.svh.
//
// Usage:
//   cmd channel carries op, card_id and entry_index; rsp channel returns
//   status, read_id and entry_count, one response item per command item.
//   Lookup, add and remove scan the RAM one entry per cycle through its single
//   read port until a hit or the end of the list; a remove hit then shifts the
//   later entries down, one read and one write per cycle. Read by index reads
//   the RAM once; clear, zero ids and unused ops go straight to the response.
//   One command is worked on at a time; cmd.ready is high only while idle.
//   The response sits in an output register, so the next command is taken
//   while a previous response still waits on rsp.ready. A stalled response
//   holds the engine in its final step until the register frees up.
//   Reset empties the list (count to zero) at once; RAM contents are left
//   as they are since only entries below the count are ever used.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module uid_allowlist_table #(
    parameter int MAX_ENTRIES = uat_pkg::MAX_ENTRIES_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    uat_cmd_if.sink         cmd,
    uat_rsp_if.source       rsp
);

    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int ID_W  = uat_pkg::ID_W;
    localparam int CO_W  = uat_pkg::COUNT_OUT_W;

    // id store
    logic [ID_W-1:0]  mem [MAX_ENTRIES];
    logic [ID_W-1:0]  rd_data_reg;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [ID_W-1:0]  mem_wdata;
    logic [IDX_W-1:0] mem_raddr;

    uat_pkg::uat_state_t  state_reg, state_next;
    logic [uat_pkg::OP_W-1:0] op_reg, op_next;
    logic [ID_W-1:0]      id_reg, id_next;
    logic [CNT_W-1:0]     ptr_reg, ptr_next;
    logic [CNT_W-1:0]     chk_reg, chk_next;
    logic                 chk_valid_reg, chk_valid_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    uat_pkg::uat_status_t res_status_reg, res_status_next;
    logic [ID_W-1:0]      res_id_reg, res_id_next;

    logic                 out_valid_reg, out_valid_next;
    uat_pkg::uat_status_t out_status_reg;
    logic [ID_W-1:0]      out_id_reg;
    logic [CO_W-1:0]      out_count_reg;
    logic                 out_load;

    logic [CNT_W-1:0]      chk_m1;
    logic [CNT_W+CO_W-1:0] count_ext;
    logic                  id_match;

    assign chk_m1    = chk_reg - CNT_W'(1);
    assign count_ext = {{CO_W{1'b0}}, count_reg};
    assign id_match  = chk_valid_reg && (rd_data_reg == id_reg);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= uat_pkg::ST_IDLE;
            count_reg     <= '0;
            chk_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            chk_valid_reg <= chk_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        id_reg         <= id_next;
        ptr_reg        <= ptr_next;
        chk_reg        <= chk_next;
        res_status_reg <= res_status_next;
        res_id_reg     <= res_id_next;
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_id_reg     <= res_id_reg;
            out_count_reg  <= count_ext[CO_W-1:0];
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        id_next         = id_reg;
        ptr_next        = ptr_reg;
        chk_next        = chk_reg;
        chk_valid_next  = chk_valid_reg;
        count_next      = count_reg;
        res_status_next = res_status_reg;
        res_id_next     = res_id_reg;
        mem_we          = 1'b0;
        mem_waddr       = count_reg[IDX_W-1:0];
        mem_wdata       = id_reg;
        mem_raddr       = ptr_reg[IDX_W-1:0];
        cmd.ready       = 1'b0;
        out_load        = 1'b0;

        unique case (state_reg)
            uat_pkg::ST_IDLE:
            begin
                cmd.ready = 1'b1;
                mem_raddr = cmd.entry_index[IDX_W-1:0];
                if (cmd.valid)
                begin
                    op_next         = cmd.op;
                    id_next         = cmd.card_id;
                    ptr_next        = '0;
                    chk_valid_next  = 1'b0;
                    res_id_next     = '0;
                    res_status_next = uat_pkg::STS_OK;
                    state_next      = uat_pkg::ST_DONE;
                    unique case (cmd.op) inside
                        uat_pkg::OP_LOOKUP, uat_pkg::OP_ADD, uat_pkg::OP_REMOVE:
                        begin
                            if (cmd.card_id == '0)
                            begin
                                res_status_next = (cmd.op == uat_pkg::OP_ADD) ?
                                    uat_pkg::STS_ZERO : uat_pkg::STS_ABSENT;
                            end
                            else
                            begin
                                state_next = uat_pkg::ST_SCAN;
                            end
                        end
                        uat_pkg::OP_CLEAR:
                        begin
                            count_next = '0;
                        end
                        uat_pkg::OP_READ:
                        begin
                            if (cmd.entry_index < count_reg)
                            begin
                                state_next = uat_pkg::ST_READ;
                            end
                            else
                            begin
                                res_status_next = uat_pkg::STS_RANGE;
                            end
                        end
                        default:
                        begin
                            res_status_next = uat_pkg::STS_OK;
                        end
                    endcase
                end
            end

            // issue one read per cycle, compare the entry read last cycle
            uat_pkg::ST_SCAN:
            begin
                if (id_match)
                begin
                    state_next = uat_pkg::ST_DONE;
                    case (op_reg)
                        uat_pkg::OP_ADD:    res_status_next = uat_pkg::STS_PRESENT;
                        uat_pkg::OP_REMOVE:
                        begin
                            ptr_next       = chk_reg + CNT_W'(1);
                            chk_valid_next = 1'b0;
                            state_next     = uat_pkg::ST_SHIFT;
                        end
                        default:            res_status_next = uat_pkg::STS_OK;
                    endcase
                end
                else if (ptr_reg == count_reg)
                begin
                    state_next = uat_pkg::ST_DONE;
                    case (op_reg)
                        uat_pkg::OP_ADD:
                        begin
                            if (count_reg >= CNT_W'(MAX_ENTRIES))
                            begin
                                res_status_next = uat_pkg::STS_FULL;
                            end
                            else
                            begin
                                mem_we          = 1'b1;
                                count_next      = count_reg + CNT_W'(1);
                                res_status_next = uat_pkg::STS_OK;
                            end
                        end
                        default: res_status_next = uat_pkg::STS_ABSENT;
                    endcase
                end
                else
                begin
                    chk_next       = ptr_reg;
                    chk_valid_next = 1'b1;
                    ptr_next       = ptr_reg + CNT_W'(1);
                end
            end

            // read entry j, write it to j-1 on the next cycle
            uat_pkg::ST_SHIFT:
            begin
                if (chk_valid_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = chk_m1[IDX_W-1:0];
                    mem_wdata = rd_data_reg;
                end
                if (ptr_reg < count_reg)
                begin
                    chk_next       = ptr_reg;
                    chk_valid_next = 1'b1;
                    ptr_next       = ptr_reg + CNT_W'(1);
                end
                else
                begin
                    chk_valid_next  = 1'b0;
                    count_next      = count_reg - CNT_W'(1);
                    res_status_next = uat_pkg::STS_OK;
                    state_next      = uat_pkg::ST_DONE;
                end
            end

            uat_pkg::ST_READ:
            begin
                res_id_next = rd_data_reg;
                state_next  = uat_pkg::ST_DONE;
            end

            uat_pkg::ST_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_load   = 1'b1;
                    state_next = uat_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = uat_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.read_id     = out_id_reg;
    assign rsp.entry_count = out_count_reg;

    `ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_reg <= CNT_W'(MAX_ENTRIES),
        "count above capacity")
    `ASSERT_IMPLIES(a_write_in_list, clk, rst_n, mem_we, mem_waddr <= count_reg,
        "write beyond list end")
    `ASSERT_IMPLIES(a_shift_nonempty, clk, rst_n, state_reg == uat_pkg::ST_SHIFT,
        count_reg != '0, "shift on empty list")
    `ASSERT_NEXT(a_count_step, clk, rst_n, state_reg != uat_pkg::ST_IDLE,
        count_reg == $past(count_reg) || count_reg == $past(count_reg) + CNT_W'(1)
            || count_reg == $past(count_reg) - CNT_W'(1),
        "count jumped while busy")

endmodule
